[rtl/core/signed_int_to_decimal_glyphs_defines.svh]
// ============================================================================
// signed_int_to_decimal_glyphs_defines
// Assertion macros shared by the decimal glyph converter.
// ============================================================================
`ifndef SIGNED_INT_TO_DECIMAL_GLYPHS_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_GLYPHS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITDG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SITDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sitdg_pkg.sv]
// ============================================================================
// sitdg_pkg
// Widths, codes, cell control type and glyph tables of the converter.
// ============================================================================
package sitdg_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int GLYPH_W     = 24;
    localparam int GLYPH_LEN_W = 2;

    localparam logic [DIGIT_W-1:0] CODE_MINUS = 4'd10;

    localparam logic GLYPH_SUB = 1'b0;
    localparam logic GLYPH_SUP = 1'b1;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [GLYPH_W-1:0] glyph_bytes(input logic set,
                                                       input logic [DIGIT_W-1:0] code);
        logic [GLYPH_W-1:0] g;
        if (set == GLYPH_SUB) begin
            case (code)
                4'd0:       g = 24'hE28280;
                4'd1:       g = 24'hE28281;
                4'd2:       g = 24'hE28282;
                4'd3:       g = 24'hE28283;
                4'd4:       g = 24'hE28284;
                4'd5:       g = 24'hE28285;
                4'd6:       g = 24'hE28286;
                4'd7:       g = 24'hE28287;
                4'd8:       g = 24'hE28288;
                4'd9:       g = 24'hE28289;
                CODE_MINUS: g = 24'hE2828B;
                default:    g = 24'hE28280;
            endcase
        end else begin
            case (code)
                4'd0:       g = 24'hE281B0;
                4'd1:       g = 24'h00C2B9;
                4'd2:       g = 24'h00C2B2;
                4'd3:       g = 24'h00C2B3;
                4'd4:       g = 24'hE281B4;
                4'd5:       g = 24'hE281B5;
                4'd6:       g = 24'hE281B6;
                4'd7:       g = 24'hE281B7;
                4'd8:       g = 24'hE281B8;
                4'd9:       g = 24'hE281B9;
                CODE_MINUS: g = 24'hE281BB;
                default:    g = 24'hE281B0;
            endcase
        end
        return g;
    endfunction

    function automatic logic [GLYPH_LEN_W-1:0] glyph_length(input logic set,
                                                            input logic [DIGIT_W-1:0] code);
        logic [GLYPH_LEN_W-1:0] n;
        n = 2'd3;
        if (set == GLYPH_SUP && (code == 4'd1 || code == 4'd2 || code == 4'd3)) begin
            n = 2'd2;
        end
        return n;
    endfunction

endpackage

[rtl/core/signed_int_to_decimal_glyphs.sv]
// ============================================================================
// signed_int_to_decimal_glyphs
// Signed integer to a run of subscript or superscript decimal glyph tokens.
// ============================================================================
// A value is taken when start is high and busy is low. Its magnitude is
// shifted, one bit per cycle, into a row of ten BCD cells, then the find
// state finds the leading digit, then the tokens leave one per cycle: a minus
// token first for a negative value, then the digits, most significant first,
// o_last on the final one. Tokens are 1 to 11. Busy falls with the final
// token, so the next value can be taken while that token is shown and not
// before. Each token is on the o_ ports for exactly one cycle with o_strobe
// high and cannot be held off, so the receiver must take every word as it
// comes. The user must write glyph_set with i_cfg_we only while busy is
// low; the block itself does not enforce it.
// ============================================================================
`include "signed_int_to_decimal_glyphs_defines.svh"

module signed_int_to_decimal_glyphs
    import sitdg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    output logic                          o_strobe,
    output logic [DIGIT_W-1:0]            o_digit_code,
    output logic [GLYPH_W-1:0]            o_glyph_bytes,
    output logic [GLYPH_LEN_W-1:0]        o_glyph_length,
    output logic                          o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BIT_CNT_W-1:0]   r_bit_cnt;
    logic                   r_neg;
    logic                   r_ovf;
    logic [DIGIT_CNT_W-1:0] r_left;
    logic                   r_glyph_set;

    logic                   w_accept;
    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_abs;
    t_cell_ctrl             w_ctrl;
    logic [DIGIT_W-1:0]     w_digit [MAX_DIGITS];
    logic [MAX_DIGITS-1:0]  w_carry;
    logic [DIGIT_CNT_W-1:0] w_count;
    logic [DIGIT_CNT_W-1:0] w_left_m1;
    logic [DIGIT_IDX_W-1:0] w_idx;
    logic [DIGIT_W-1:0]     w_code;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_raw    = i_value;
    assign w_abs    = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;

    assign w_ctrl.clr   = w_accept;
    assign w_ctrl.shift = (r_state == S_CONV);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                sitdg_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_ctrl),
                    .i_bit   (r_mag[VALUE_WIDTH-1]),
                    .o_carry (w_carry[gi]),
                    .o_digit (w_digit[gi])
                );
            end else begin : g_body
                sitdg_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctrl  (w_ctrl),
                    .i_bit   (w_carry[gi-1]),
                    .o_carry (w_carry[gi]),
                    .o_digit (w_digit[gi])
                );
            end
        end
    endgenerate

    // digit count: position of the highest nonzero cell, at least one;
    // the whole row if a carry fell off the top
    always_comb begin
        w_count = DIGIT_CNT_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (w_digit[i] != '0) begin
                w_count = DIGIT_CNT_W'(i + 1);
            end
        end
        if (r_ovf) begin
            w_count = DIGIT_CNT_W'(MAX_DIGITS);
        end
    end

    assign w_left_m1 = r_left - DIGIT_CNT_W'(1);
    assign w_idx     = w_left_m1[DIGIT_IDX_W-1:0];
    assign w_code    = r_neg ? CODE_MINUS : w_digit[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_neg       <= 1'b0;
            r_ovf       <= 1'b0;
            r_left      <= '0;
            r_glyph_set <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_glyph_set <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag     <= w_abs;
                        r_neg     <= w_raw[VALUE_WIDTH-1];
                        r_ovf     <= 1'b0;
                        r_bit_cnt <= BIT_CNT_W'(VALUE_WIDTH - 1);
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= r_mag << 1;
                    if (w_carry[MAX_DIGITS-1]) begin
                        r_ovf <= 1'b1;
                    end
                    if (r_bit_cnt == '0) begin
                        r_state <= S_FIND;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                S_FIND: begin
                    r_left  <= w_count;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_strobe       <= 1'b1;
                    o_digit_code   <= w_code;
                    o_glyph_bytes  <= glyph_bytes(r_glyph_set, w_code);
                    o_glyph_length <= glyph_length(r_glyph_set, w_code);
                    if (r_neg) begin
                        o_last <= 1'b0;
                        r_neg  <= 1'b0;
                    end else begin
                        o_last <= (r_left == DIGIT_CNT_W'(1));
                        r_left <= w_left_m1;
                        if (r_left == DIGIT_CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SITDG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy && !o_strobe, "accept did not start a conversion")
    `SITDG_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last, !o_strobe, "word followed the last token")
    `SITDG_ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, o_strobe && o_last, !busy, "busy held after the last token")
    `SITDG_ASSERT_IMPL(a_minus_first, i_clk, i_rst_n, o_strobe && o_digit_code == CODE_MINUS, !o_last, "minus token marked last")
    `SITDG_ASSERT_IMPL(a_len, i_clk, i_rst_n, o_strobe, o_glyph_length == 2'd2 || o_glyph_length == 2'd3, "bad glyph length")

endmodule

[rtl/core/sitdg_cell.sv]
// ============================================================================
// sitdg_cell
// One BCD digit of the shift-add-3 chain.
// ============================================================================
module sitdg_cell
    import sitdg_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_bit,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    always_comb begin
        // correct before the doubling so the digit never passes nine
        w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        n_digit = r_digit;
        if (i_ctrl.clr) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

endmodule
